[rtl/core/cga_graphics_pixel_generator_macros.svh]
// Assertion macros for the CGA pixel generator checker.
// Used only by the checker file; needs no package.
`ifndef CGA_GRAPHICS_PIXEL_GENERATOR_MACROS_SVH
`define CGA_GRAPHICS_PIXEL_GENERATOR_MACROS_SVH

// check on every edge, skipped while reset is low
`define CGAPG_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check on every edge, reset included
`define CGAPG_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[rtl/core/cgapg_pkg.sv]
// Shared types, codes and constants of the CGA pixel generator.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package cgapg_pkg;

    localparam int VRAM_BYTES = 16384;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);
    localparam int ODD_BANK   = 8192;
    localparam int BANK_AW    = $clog2(ODD_BANK);
    localparam int FRAME_W    = 320;
    localparam int FRAME_H    = 200;
    localparam int QDEPTH     = 2;
    localparam int QPW        = $clog2(QDEPTH);
    localparam int QCW        = $clog2(QDEPTH + 1);
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;

    localparam logic [6:0] MODE_GFX_4 = 7'd4;
    localparam logic [6:0] MODE_GFX_5 = 7'd5;
    localparam logic [6:0] MODE_GFX_6 = 7'd6;

    localparam logic REG_VIDEO_MODE   = 1'b0;
    localparam logic REG_COLOR_SELECT = 1'b1;

    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_WRITE = 3'd1;
    localparam logic [2:0] K_READ  = 3'd2;
    localparam logic [2:0] K_PIX2  = 3'd3;
    localparam logic [2:0] K_PIX1  = 3'd4;

    localparam logic [15:0] RGB565_LUT [0:15] = '{
        16'h0000, 16'h0015, 16'h0540, 16'h0555, 16'hA800, 16'hA815, 16'hAAA0, 16'hAD55,
        16'h52AA, 16'h52BF, 16'h57EA, 16'h57FF, 16'hFAAA, 16'hFABF, 16'hFFEA, 16'hFFFF
    };

    typedef struct packed {
        logic [2:0]         kind;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         wdata;
        logic [2:0]         sel;
        logic               pal;
        logic               inten;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_beat;

endpackage

[rtl/core/cgapg_regs.sv]
// APB configuration registers: video mode and colour select.
// Depends on cgapg_pkg.
`timescale 1ns / 1ps

module cgapg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cgapg_pkg::CFG_AW-1:0]  paddr,
    input  logic [cgapg_pkg::CFG_DW-1:0]  pwdata,
    output logic [cgapg_pkg::CFG_DW-1:0]  prdata,
    output logic                          pready,
    output logic [6:0]                    o_video_mode,
    output logic [7:0]                    o_color_select
);

    logic       w_video_mode_we;
    logic [6:0] r_video_mode;
    logic [7:0] r_color_select;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_video_mode_we = w_wr & (paddr[2] == cgapg_pkg::REG_VIDEO_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_mode   <= '0;
            r_color_select <= '0;
        end else if (w_video_mode_we) begin
            r_video_mode <= pwdata[6:0];
        end else if (w_wr) begin
            r_color_select <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            cgapg_pkg::REG_VIDEO_MODE:   prdata = {25'b0, r_video_mode};
            cgapg_pkg::REG_COLOR_SELECT: prdata = {24'b0, r_color_select};
            default:                     prdata = '0;
        endcase
    end

    assign o_video_mode   = r_video_mode;
    assign o_color_select = r_color_select;

endmodule

[rtl/core/cgapg_front.sv]
// Front end: classifies an accepted item into a memory command.
// Depends on cgapg_pkg.
`timescale 1ns / 1ps

module cgapg_front (
    input  logic                 i_accept,
    input  logic [1:0]           i_operation,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_write_data,
    input  logic [8:0]           i_pixel_x,
    input  logic [7:0]           i_pixel_y,
    input  logic [6:0]           i_video_mode,
    input  logic [7:0]           i_color_select,
    output cgapg_pkg::t_beat     o_push
);

    localparam int BW = cgapg_pkg::BANK_AW;

    logic          w_in_ram;
    logic          w_in_frame;
    logic [BW-1:0] w_off2;
    logic [BW-1:0] w_off1;
    logic [5:0]    w_row1;
    logic [6:0]    w_row2;

    assign w_in_ram   = i_address < 16'(cgapg_pkg::VRAM_BYTES);
    assign w_in_frame = (i_pixel_x < 9'(cgapg_pkg::FRAME_W))
                      & (i_pixel_y < 8'(cgapg_pkg::FRAME_H));

    assign w_row2 = i_pixel_y[7:1];
    assign w_row1 = i_pixel_y[7:2];
    assign w_off2 = BW'({w_row2, 6'b0}) + BW'({w_row2, 4'b0}) + BW'(i_pixel_x[8:2]);
    assign w_off1 = BW'({w_row1, 6'b0}) + BW'({w_row1, 4'b0}) + BW'(i_pixel_x[8:3]);

    always_comb begin
        o_push.valid     = i_accept;
        o_push.cmd.kind  = cgapg_pkg::K_NONE;
        o_push.cmd.addr  = i_address[cgapg_pkg::VRAM_AW-1:0];
        o_push.cmd.wdata = i_write_data;
        o_push.cmd.sel   = i_pixel_x[2:0];
        o_push.cmd.pal   = i_color_select[5];
        o_push.cmd.inten = i_color_select[4];
        unique case (i_operation)
            cgapg_pkg::OP_WRITE: begin
                if (w_in_ram) o_push.cmd.kind = cgapg_pkg::K_WRITE;
            end
            cgapg_pkg::OP_READ: begin
                if (w_in_ram) o_push.cmd.kind = cgapg_pkg::K_READ;
            end
            cgapg_pkg::OP_PIXEL: begin
                if (w_in_frame) begin
                    priority if (i_video_mode == cgapg_pkg::MODE_GFX_4
                              || i_video_mode == cgapg_pkg::MODE_GFX_5) begin
                        o_push.cmd.kind = cgapg_pkg::K_PIX2;
                        o_push.cmd.addr = {i_pixel_y[0], w_off2};
                        o_push.cmd.sel  = {1'b0, i_pixel_x[1:0]};
                    end else if (i_video_mode == cgapg_pkg::MODE_GFX_6) begin
                        o_push.cmd.kind = cgapg_pkg::K_PIX1;
                        o_push.cmd.addr = {i_pixel_y[1], w_off1};
                    end else begin
                        o_push.cmd.kind = cgapg_pkg::K_NONE;
                    end
                end
            end
            default: o_push.cmd.kind = cgapg_pkg::K_NONE;
        endcase
    end

endmodule

[rtl/core/cgapg_queue.sv]
// Short command queue between the front end and the memory back end.
// Depends on cgapg_pkg.
`timescale 1ns / 1ps

module cgapg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cgapg_pkg::t_beat i_push,
    input  logic             i_pop,
    output cgapg_pkg::t_beat o_head,
    output logic             o_full
);

    localparam int QW = cgapg_pkg::QPW;
    localparam int CW = cgapg_pkg::QCW;

    cgapg_pkg::t_cmd r_slot [cgapg_pkg::QDEPTH];
    logic [QW-1:0]   r_wptr;
    logic [QW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic            w_do_push;
    logic            w_do_pop;

    assign o_full     = r_count == CW'(cgapg_pkg::QDEPTH);
    assign w_do_push  = i_push.valid & ~o_full;
    assign w_do_pop   = i_pop & (r_count != '0);
    assign o_head.valid = r_count != '0;
    assign o_head.cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) r_wptr <= r_wptr + QW'(1);
            if (w_do_pop)  r_rptr <= r_rptr + QW'(1);
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/cgapg_back.sv]
// Back end: video RAM with clearing pass, access stage and result formatting.
// Depends on cgapg_pkg.
`timescale 1ns / 1ps

module cgapg_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cgapg_pkg::t_beat         i_head,
    output logic                     o_pop,
    output logic                     o_clearing,
    output logic                     o_done,
    output logic [7:0]               o_read_data,
    output logic [15:0]              o_pixel_rgb565,
    output logic                     o_pixel_valid
);

    localparam int AW = cgapg_pkg::VRAM_AW;

    logic [7:0]    r_mem [cgapg_pkg::VRAM_BYTES];
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          r_s1_valid;
    logic [2:0]    r_s1_kind;
    logic [2:0]    r_s1_sel;
    logic          r_s1_pal;
    logic          r_s1_inten;
    logic [7:0]    r_rd_byte;
    logic          r_done;
    logic [7:0]    r_read_data;
    logic [15:0]   r_rgb;
    logic          r_pv;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [1:0]    w_c;
    logic [3:0]    w_idx;
    logic [7:0]    n_read_data;
    logic [15:0]   n_rgb;
    logic          n_pv;

    assign o_pop      = i_head.valid & ~r_clearing;
    assign o_clearing = r_clearing;

    assign w_we    = r_clearing | (o_pop & (i_head.cmd.kind == cgapg_pkg::K_WRITE));
    assign w_waddr = r_clearing ? r_clr_addr : i_head.cmd.addr;
    assign w_wdata = r_clearing ? 8'h00 : i_head.cmd.wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_byte <= r_mem[i_head.cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(cgapg_pkg::VRAM_BYTES - 1)) r_clearing <= 1'b0;
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_pop;
        end
        r_s1_kind  <= i_head.cmd.kind;
        r_s1_sel   <= i_head.cmd.sel;
        r_s1_pal   <= i_head.cmd.pal;
        r_s1_inten <= i_head.cmd.inten;
    end

    always_comb begin
        unique case (r_s1_sel[1:0])
            2'd0:    w_c = r_rd_byte[7:6];
            2'd1:    w_c = r_rd_byte[5:4];
            2'd2:    w_c = r_rd_byte[3:2];
            default: w_c = r_rd_byte[1:0];
        endcase
        w_idx = (w_c == 2'd0) ? 4'd0 : {r_s1_inten, w_c, r_s1_pal};

        n_read_data = 8'h00;
        n_rgb       = 16'h0000;
        n_pv        = 1'b0;
        unique case (r_s1_kind)
            cgapg_pkg::K_READ: n_read_data = r_rd_byte;
            cgapg_pkg::K_PIX2: begin
                n_rgb = cgapg_pkg::RGB565_LUT[w_idx];
                n_pv  = 1'b1;
            end
            cgapg_pkg::K_PIX1: begin
                n_rgb = r_rd_byte[~r_s1_sel] ? cgapg_pkg::RGB565_LUT[15]
                                             : cgapg_pkg::RGB565_LUT[0];
                n_pv  = 1'b1;
            end
            default: begin
                n_read_data = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_valid;
        end
        r_read_data <= n_read_data;
        r_rgb       <= n_rgb;
        r_pv        <= n_pv;
    end

    assign o_done         = r_done;
    assign o_read_data    = r_read_data;
    assign o_pixel_rgb565 = r_rgb;
    assign o_pixel_valid  = r_pv;

endmodule

[rtl/core/cga_graphics_pixel_generator.sv]
// Top level of the CGA graphics pixel generator: registers, front end, queue, back end.
// Depends on cgapg_pkg, cgapg_regs, cgapg_front, cgapg_queue, cgapg_back.
//
//  channel   handshake                      payload
//  -------   ---------------------------    ---------------------------------------------
//  item      start high, busy low           i_operation i_address i_write_data i_pixel_x/y
//  result    o_done strobe, one cycle       o_read_data o_pixel_rgb565 o_pixel_valid
//  config    psel penable pwrite pready     paddr pwdata / prdata
//
// One item per clock unless busy; results pass the queue, access stage and output registers.
// The single video RAM port sets the rate: one access per item.
// After reset the RAM is cleared one byte a cycle; busy stays high until every byte is zero.
// busy also rises when the command queue is full; the result side never stalls.
`timescale 1ns / 1ps

module cga_graphics_pixel_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_operation,
    input  logic [15:0]                   i_address,
    input  logic [7:0]                    i_write_data,
    input  logic [8:0]                    i_pixel_x,
    input  logic [7:0]                    i_pixel_y,
    output logic                          o_done,
    output logic [7:0]                    o_read_data,
    output logic [15:0]                   o_pixel_rgb565,
    output logic                          o_pixel_valid,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cgapg_pkg::CFG_AW-1:0]  paddr,
    input  logic [cgapg_pkg::CFG_DW-1:0]  pwdata,
    output logic [cgapg_pkg::CFG_DW-1:0]  prdata,
    output logic                          pready
);

    logic             w_accept;
    logic [6:0]       w_video_mode;
    logic [7:0]       w_color_select;
    cgapg_pkg::t_beat w_push;
    cgapg_pkg::t_beat w_head;
    logic             w_pop;
    logic             w_full;
    logic             w_clearing;

    assign busy     = w_clearing | w_full;
    assign w_accept = start & ~busy;

    cgapg_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_video_mode   (w_video_mode),
        .o_color_select (w_color_select)
    );

    cgapg_front u_front (
        .i_accept       (w_accept),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_video_mode   (w_video_mode),
        .i_color_select (w_color_select),
        .o_push         (w_push)
    );

    cgapg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    cgapg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_clearing     (w_clearing),
        .o_done         (o_done),
        .o_read_data    (o_read_data),
        .o_pixel_rgb565 (o_pixel_rgb565),
        .o_pixel_valid  (o_pixel_valid)
    );

endmodule

[rtl/core/cgapg_checker.sv]
// Port-level checker for the CGA pixel generator, bound to the top level.
// Depends on cga_graphics_pixel_generator_macros.svh.
`timescale 1ns / 1ps
`include "cga_graphics_pixel_generator_macros.svh"

module cgapg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [7:0]  o_read_data,
    input logic [15:0] o_pixel_rgb565,
    input logic        o_pixel_valid
);

    `CGAPG_ASSERT_ALL(a_clear_after_reset, i_clk, !i_rst_n |=> busy, "busy low after reset")
    `CGAPG_ASSERT_RUN(a_beat_follows, i_clk, i_rst_n, (start && !busy) |-> ##3 o_done, "result beat missing")
    `CGAPG_ASSERT_RUN(a_beat_has_item, i_clk, i_rst_n, o_done |-> $past(start && !busy, 3), "result beat without item")
    `CGAPG_ASSERT_RUN(a_pixel_no_read, i_clk, i_rst_n, (o_done && o_pixel_valid) |-> (o_read_data == 8'h00), "read data on pixel beat")
    `CGAPG_ASSERT_RUN(a_invalid_black, i_clk, i_rst_n, (o_done && !o_pixel_valid) |-> (o_pixel_rgb565 == 16'h0000), "colour without valid pixel")

endmodule

bind cga_graphics_pixel_generator cgapg_checker u_cgapg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_read_data    (o_read_data),
    .o_pixel_rgb565 (o_pixel_rgb565),
    .o_pixel_valid  (o_pixel_valid)
);

[tb/cga_graphics_pixel_generator_test.sv]
// Self-checking testbench for the CGA graphics pixel generator: byte writes, reads and pixel fetches.
// Depends on cgapg_pkg and cga_graphics_pixel_generator; a scoreboard class tracks video RAM and
// registers and checks every result beat.
`timescale 1ns / 1ps

module cga_graphics_pixel_generator_test;

    localparam logic [1:0] OP_UNUSED         = 2'd3;
    localparam logic [2:0] ADDR_VIDEO_MODE   = 3'd0;
    localparam logic [2:0] ADDR_COLOR_SELECT = 3'd4;
    localparam int         WATCHDOG_CYCLES   = 100000;
    localparam int         PHASE_ITEMS       = 220;
    localparam int         AW                = cgapg_pkg::VRAM_AW;

    localparam logic [15:0] CGA_COLORS [16] = '{
        16'h0000, 16'h0015, 16'h0540, 16'h0555, 16'hA800, 16'hA815, 16'hAAA0, 16'hAD55,
        16'h52AA, 16'h52BF, 16'h57EA, 16'h57FF, 16'hFAAA, 16'hFABF, 16'hFFEA, 16'hFFFF
    };

    typedef struct {
        logic [7:0]  read_data;
        logic [15:0] rgb;
        logic        valid;
    } t_pixel_beat;

    class cga_frame_tracker;
        logic [7:0]  vram [cgapg_pkg::VRAM_BYTES];
        logic [6:0]  mode;
        logic [7:0]  csel;
        t_pixel_beat pending_beats [$];
        int          failures;

        function new();
            foreach (vram[i]) vram[i] = 8'h00;
            mode     = 7'd0;
            csel     = 8'h00;
            failures = 0;
        endfunction

        function void set_reg(logic [2:0] addr, logic [31:0] value);
            if (addr == ADDR_VIDEO_MODE) mode = value[6:0];
            else if (addr == ADDR_COLOR_SELECT) csel = value[7:0];
        endfunction

        function void note_item(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata,
                                logic [8:0] px, logic [7:0] py);
            t_pixel_beat beat;
            int          xi;
            int          yi;
            int          yh;
            int          a;
            int          c;
            int          idx;
            logic [7:0]  b;
            beat = '{8'h00, 16'h0000, 1'b0};
            xi   = int'(px);
            yi   = int'(py);
            case (op)
                cgapg_pkg::OP_WRITE: begin
                    if (addr < cgapg_pkg::VRAM_BYTES) vram[addr[AW-1:0]] = wdata;
                end
                cgapg_pkg::OP_READ: begin
                    if (addr < cgapg_pkg::VRAM_BYTES) beat.read_data = vram[addr[AW-1:0]];
                end
                cgapg_pkg::OP_PIXEL: begin
                    if (xi < cgapg_pkg::FRAME_W && yi < cgapg_pkg::FRAME_H) begin
                        if (mode == cgapg_pkg::MODE_GFX_4 || mode == cgapg_pkg::MODE_GFX_5) begin
                            a   = (yi % 2) * cgapg_pkg::ODD_BANK + (yi / 2) * 80 + xi / 4;
                            b   = vram[AW'(a)];
                            c   = (b >> (6 - 2 * (xi % 4))) & 3;
                            idx = (c == 0) ? 0 : c * 2 + csel[5] + 8 * csel[4];
                            beat.rgb   = CGA_COLORS[4'(idx)];
                            beat.valid = 1'b1;
                        end else if (mode == cgapg_pkg::MODE_GFX_6) begin
                            yh  = yi / 2;
                            a   = (yh % 2) * cgapg_pkg::ODD_BANK + (yh / 2) * 80 + xi / 8;
                            b   = vram[AW'(a)];
                            beat.rgb   = b[3'(7 - xi % 8)] ? CGA_COLORS[15] : CGA_COLORS[0];
                            beat.valid = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            pending_beats.push_back(beat);
        endfunction

        function void check_beat(logic [7:0] rd, logic [15:0] rgb, logic valid);
            t_pixel_beat exp_beat;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected result beat rd=%h rgb=%h valid=%b", $time, rd, rgb,
                         valid);
                failures++;
                return;
            end
            exp_beat = pending_beats.pop_front();
            if (rd !== exp_beat.read_data) begin
                $display("%0t: read_data expected %h actual %h", $time, exp_beat.read_data, rd);
                failures++;
            end
            if (rgb !== exp_beat.rgb) begin
                $display("%0t: pixel_rgb565 expected %h actual %h", $time, exp_beat.rgb, rgb);
                failures++;
            end
            if (valid !== exp_beat.valid) begin
                $display("%0t: pixel_valid expected %b actual %b", $time, exp_beat.valid, valid);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic [1:0]  i_operation  = 2'd0;
    logic [15:0] i_address    = 16'h0000;
    logic [7:0]  i_write_data = 8'h00;
    logic [8:0]  i_pixel_x    = 9'd0;
    logic [7:0]  i_pixel_y    = 8'd0;
    logic        o_done;
    logic [7:0]  o_read_data;
    logic [15:0] o_pixel_rgb565;
    logic        o_pixel_valid;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [cgapg_pkg::CFG_AW-1:0] paddr  = '0;
    logic [cgapg_pkg::CFG_DW-1:0] pwdata = '0;
    logic [cgapg_pkg::CFG_DW-1:0] prdata;
    logic        pready;

    cga_frame_tracker tracker = new();
    int               idle_pct    = 0;
    int               idle_cycles = 0;

    cga_graphics_pixel_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_done         (o_done),
        .o_read_data    (o_read_data),
        .o_pixel_rgb565 (o_pixel_rgb565),
        .o_pixel_valid  (o_pixel_valid),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            tracker.check_beat(o_read_data, o_pixel_rgb565, o_pixel_valid);
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic drive_item(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata,
                              logic [8:0] px, logic [7:0] py);
        while (int'($urandom_range(99)) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_operation  <= op;
        i_address    <= addr;
        i_write_data <= wdata;
        i_pixel_x    <= px;
        i_pixel_y    <= py;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_item(op, addr, wdata, px, py);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (tracker.pending_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        tracker.set_reg(addr, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int hot_row();
        return $urandom_range(1) ? int'($urandom_range(3)) : int'($urandom_range(199, 196));
    endfunction

    function automatic logic [15:0] pick_address();
        int r;
        int xx;
        int yy;
        int yh;
        r = int'($urandom_range(99));
        if (r < 70) begin
            xx = int'($urandom_range(319));
            yy = hot_row();
            yh = yy / 2;
            if ($urandom_range(1)) begin
                return 16'((yy % 2) * cgapg_pkg::ODD_BANK + (yy / 2) * 80 + xx / 4);
            end
            return 16'((yh % 2) * cgapg_pkg::ODD_BANK + (yh / 2) * 80 + xx / 8);
        end
        if (r < 85) return 16'($urandom_range(cgapg_pkg::VRAM_BYTES - 1));
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic drive_random_item();
        int          r;
        logic [1:0]  op;
        logic [8:0]  px;
        logic [7:0]  py;
        r = int'($urandom_range(99));
        if (r < 30) op = cgapg_pkg::OP_WRITE;
        else if (r < 50) op = cgapg_pkg::OP_READ;
        else if (r < 95) op = cgapg_pkg::OP_PIXEL;
        else op = OP_UNUSED;
        if ($urandom_range(9) == 0) begin
            px = 9'($urandom_range(511));
            py = 8'($urandom_range(255));
        end else begin
            px = 9'($urandom_range(cgapg_pkg::FRAME_W - 1));
            py = 8'(hot_row());
        end
        drive_item(op, pick_address(), 8'($urandom_range(255)), px, py);
    endtask

    initial begin
        logic [6:0] phase_mode [8];
        logic [7:0] phase_csel [8];
        phase_mode = '{7'd4, 7'd5, 7'd6, 7'd0, 7'd4, 7'd127, 7'd5, 7'd6};
        phase_csel = '{8'h00, 8'h20, 8'hFF, 8'hCF, 8'h10, 8'h55, 8'h30, 8'h00};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (busy !== 1'b0) @(posedge i_clk);

        write_reg(ADDR_VIDEO_MODE, 32'(cgapg_pkg::MODE_GFX_4));
        write_reg(ADDR_COLOR_SELECT, 32'h30);
        drive_item(cgapg_pkg::OP_WRITE, 16'd0, 8'hE4, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_WRITE, 16'd16383, 8'hFF, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_WRITE, 16'd16384, 8'h12, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_WRITE, 16'hFFFF, 8'hAA, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_WRITE, 16'd16191, 8'h55, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_WRITE, 16'd8192, 8'h81, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_READ, 16'd0, 8'h00, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_READ, 16'd16383, 8'h00, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_READ, 16'd16384, 8'h00, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_READ, 16'hFFFF, 8'h00, 9'd0, 8'd0);
        drive_item(cgapg_pkg::OP_READ, 16'd16191, 8'h00, 9'd0, 8'd0);
        for (int i = 0; i < 4; i++) begin
            drive_item(cgapg_pkg::OP_PIXEL, 16'd0, 8'h00, 9'(i), 8'd0);
        end
        drive_item(cgapg_pkg::OP_PIXEL, 16'd0, 8'h00, 9'd0, 8'd1);
        drive_item(cgapg_pkg::OP_PIXEL, 16'd0, 8'h00, 9'd3, 8'd1);
        drive_item(cgapg_pkg::OP_PIXEL, 16'd0, 8'h00, 9'd319, 8'd199);
        drive_item(cgapg_pkg::OP_PIXEL, 16'd0, 8'h00, 9'd318, 8'd199);
        drive_item(cgapg_pkg::OP_PIXEL, 16'd0, 8'h00, 9'd320, 8'd0);
        drive_item(cgapg_pkg::OP_PIXEL, 16'd0, 8'h00, 9'd0, 8'd200);
        drive_item(cgapg_pkg::OP_PIXEL, 16'hFFFF, 8'hFF, 9'd511, 8'd255);
        drive_item(OP_UNUSED, 16'hFFFF, 8'hFF, 9'd511, 8'd255);

        for (int p = 0; p < 8; p++) begin
            drain_results();
            write_reg(ADDR_VIDEO_MODE, 32'(phase_mode[p]));
            write_reg(ADDR_COLOR_SELECT, 32'(phase_csel[p]));
            idle_pct = (p < 3) ? 25 : (p < 6) ? 53 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == PHASE_ITEMS / 2) drain_results();
                drive_random_item();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_beats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
